/* rtl/u16u8_pkg.sv */
// shared types and constants for the utf-16 to utf-8 encoder
package u16u8_pkg;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned RUN_MAX = 4;
    localparam int unsigned IDX_W   = $clog2(RUN_MAX);
    localparam int unsigned CP_W    = 21;
    localparam int unsigned SUR_W   = 10;

    // queue depth, power of two
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic [CP_W-1:0]   CP_ONE_MAX   = 21'h00007F;
    localparam logic [CP_W-1:0]   CP_TWO_MAX   = 21'h0007FF;
    localparam logic [CP_W-1:0]   CP_THREE_MAX = 21'h00FFFF;
    localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h010000;
    localparam logic [UNIT_W-1:0] SUR_LO       = 16'hD800;
    localparam logic [UNIT_W-1:0] SUR_HI       = 16'hDFFF;

    localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;

    localparam logic [IDX_W-1:0] IDX_ONE   = 2'd0;
    localparam logic [IDX_W-1:0] IDX_TWO   = 2'd1;
    localparam logic [IDX_W-1:0] IDX_THREE = 2'd2;
    localparam logic [IDX_W-1:0] IDX_FOUR  = 2'd3;

    typedef struct packed {
        logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]               last_idx;
        logic                           string_end;
    } t_run;

endpackage

/* rtl/u16u8_front.sv */
// front end: classifies code units, pairs surrogates and builds byte runs
module u16u8_front import u16u8_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [UNIT_W-1:0] i_unit,
    output logic              o_run_push,
    output t_run              o_run
);

    logic             r_pending;
    logic [SUR_W-1:0] r_held;
    logic             n_pending;
    logic [SUR_W-1:0] n_held;
    logic [CP_W-1:0]  cp;
    logic             is_zero;
    logic             is_sur;

    assign is_zero = (i_unit == '0);
    assign is_sur  = (i_unit >= SUR_LO) && (i_unit <= SUR_HI);

    always_comb begin
        if (r_pending) begin
            cp = {1'b0, r_held, i_unit[SUR_W-1:0]} + CP_SUPP_BASE;
        end else begin
            cp = {{(CP_W-UNIT_W){1'b0}}, i_unit};
        end
    end

    always_comb begin
        o_run = '0;
        if (is_zero) begin
            o_run.string_end = 1'b1;
            o_run.last_idx   = IDX_ONE;
        end else if (cp <= CP_ONE_MAX) begin
            o_run.bytes[0] = cp[BYTE_W-1:0];
            o_run.last_idx = IDX_ONE;
        end else if (cp <= CP_TWO_MAX) begin
            o_run.bytes[0] = LEAD_TWO  | {3'b000, cp[10:6]};
            o_run.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            o_run.last_idx = IDX_TWO;
        end else if (cp <= CP_THREE_MAX) begin
            o_run.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            o_run.bytes[1] = CONT_MARK  | {2'b00, cp[11:6]};
            o_run.bytes[2] = CONT_MARK  | {2'b00, cp[5:0]};
            o_run.last_idx = IDX_THREE;
        end else begin
            o_run.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            o_run.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
            o_run.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
            o_run.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
            o_run.last_idx = IDX_FOUR;
        end
    end

    // a lone surrogate is held and produces no run
    assign o_run_push = i_accept && (is_zero || r_pending || !is_sur);

    always_comb begin
        n_pending = r_pending;
        n_held    = r_held;
        if (i_accept) begin
            if (is_zero || r_pending) begin
                n_pending = 1'b0;
                n_held    = '0;
            end else if (is_sur) begin
                n_pending = 1'b1;
                n_held    = i_unit[SUR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= '0;
        end else begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

endmodule

/* rtl/u16u8_queue.sv */
// short queue of byte runs between front and back
module u16u8_queue import u16u8_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_run o_head
);

    t_run            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;
    logic [Q_AW-1:0] n_wptr;
    logic [Q_AW-1:0] n_rptr;
    logic [Q_AW:0]   n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("run pushed into full queue");

endmodule

/* rtl/u16u8_back.sv */
// back end: sends queued runs out one byte per cycle while pop is asserted, through an output register
module u16u8_back import u16u8_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_run              i_q_head,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last,
    output logic              o_end
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_end;
    logic [IDX_W-1:0]  r_idx;
    logic              n_valid;
    logic [IDX_W-1:0]  n_idx;
    logic              load;
    logic              at_last;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign at_last = (r_idx == i_q_head.last_idx);
    assign o_q_pop = load && at_last;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = at_last ? '0 : r_idx + 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_q_head.bytes[r_idx];
            r_last <= at_last;
            r_end  <= i_q_head.string_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_empty = !r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_end   = r_end;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> r_idx <= i_q_head.last_idx)
        else $error("byte index past end of run");

    a_end_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_end) |-> (r_byte == '0 && r_last))
        else $error("end of string byte malformed");

endmodule

/* rtl/utf16_to_utf8_encoder_top.sv */
// top level of the utf-16 to utf-8 encoder
// Takes one UTF-16 code unit per transaction on the push side and returns its UTF-8 bytes, one
// byte per pop transaction, with o_run_last on the final byte of each run and o_string_end on
// the 0x00 byte that a zero unit produces. A surrogate unit produces no bytes; the unit after
// it is combined with it into a four-byte run unless it is a zero unit. The input side takes a
// unit in the cycle it is offered while the two-entry run queue has room; the output register
// sends one byte per cycle while pop is asserted and bytes are queued, and that byte rate sets
// the sustained throughput. The bytes of a run pass through the run queue and then the output
// register.
module utf16_to_utf8_encoder_top import u16u8_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [UNIT_W-1:0] i_code_unit,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_run_last,
    output logic              o_string_end
);

    logic q_full;
    logic q_empty;
    logic q_pop;
    logic run_push;
    t_run run_in;
    t_run run_head;

    u16u8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !q_full),
        .i_unit     (i_code_unit),
        .o_run_push (run_push),
        .o_run      (run_in)
    );

    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (run_push),
        .i_data  (run_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (run_head)
    );

    u16u8_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (run_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_byte    (o_out_byte),
        .o_last    (o_run_last),
        .o_end     (o_string_end)
    );

    assign full = q_full;

endmodule

/* verif/tb_top.sv */
// testbench for the utf-16 to utf-8 encoder: random units, bursty push, stalled pop, byte checks
`timescale 1ns / 1ps

module tb_top;
    import u16u8_pkg::*;

    localparam int unsigned N_RANDOM    = 188;
    localparam int unsigned IDLE_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              run_last;
        logic              string_end;
    } t_utf8_byte;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [UNIT_W-1:0] i_code_unit;
    logic              empty;
    logic              pop;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_run_last;
    logic              o_string_end;

    logic [UNIT_W-1:0] pending_units [$];
    t_utf8_byte        expected_bytes [$];

    // predictor copy of the surrogate holding register
    logic              held_valid;
    logic [SUR_W-1:0]  held_bits;

    int unsigned total_units;
    int unsigned units_accepted;
    int unsigned bytes_checked;
    int unsigned strings_ended;
    int unsigned pairs_sent;
    int unsigned error_count;
    int unsigned idle_cycles;

    // sender and receiver idling state
    int unsigned       burst_left;
    int unsigned       gap_left;
    logic              unit_taken;
    logic [15:0]       pop_pattern;
    int unsigned       pop_phase;

    logic [UNIT_W-1:0] directed_units [22] = '{
        16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD7FF,
        16'hE000, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hD834, 16'h0000, 16'hDC05,
        16'h0041, 16'hD801, 16'hDBFF, 16'hD800, 16'hFFFF, 16'h8000
    };

    utf16_to_utf8_encoder_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_code_unit  (i_code_unit),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_utf8_byte make_byte(logic [BYTE_W-1:0] value, logic run_last);
        t_utf8_byte b;
        b.value      = value;
        b.run_last   = run_last;
        b.string_end = 1'b0;
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] cont_byte(logic [5:0] bits);
        return CONT_MARK | {2'b00, bits};
    endfunction

    // queues the utf-8 bytes that one accepted code unit produces
    function automatic void encode_unit(logic [UNIT_W-1:0] unit);
        logic [CP_W-1:0] cp;
        t_utf8_byte      term;
        if (unit == '0) begin
            held_valid = 1'b0;
            held_bits  = '0;
            term.value      = '0;
            term.run_last   = 1'b1;
            term.string_end = 1'b1;
            expected_bytes.push_back(term);
            strings_ended++;
            return;
        end
        if (held_valid) begin
            cp = CP_SUPP_BASE + CP_W'({held_bits, unit[SUR_W-1:0]});
            held_valid = 1'b0;
            held_bits  = '0;
            pairs_sent++;
        end else if (unit >= SUR_LO && unit <= SUR_HI) begin
            held_valid = 1'b1;
            held_bits  = unit[SUR_W-1:0];
            return;
        end else begin
            cp = CP_W'(unit);
        end
        if (cp <= CP_ONE_MAX) begin
            expected_bytes.push_back(make_byte(cp[7:0], 1'b1));
        end else if (cp <= CP_TWO_MAX) begin
            expected_bytes.push_back(make_byte(LEAD_TWO | {3'b000, cp[10:6]}, 1'b0));
            expected_bytes.push_back(make_byte(cont_byte(cp[5:0]), 1'b1));
        end else if (cp <= CP_THREE_MAX) begin
            expected_bytes.push_back(make_byte(LEAD_THREE | {4'b0000, cp[15:12]}, 1'b0));
            expected_bytes.push_back(make_byte(cont_byte(cp[11:6]), 1'b0));
            expected_bytes.push_back(make_byte(cont_byte(cp[5:0]), 1'b1));
        end else begin
            expected_bytes.push_back(make_byte(LEAD_FOUR | {5'b00000, cp[20:18]}, 1'b0));
            expected_bytes.push_back(make_byte(cont_byte(cp[17:12]), 1'b0));
            expected_bytes.push_back(make_byte(cont_byte(cp[11:6]), 1'b0));
            expected_bytes.push_back(make_byte(cont_byte(cp[5:0]), 1'b1));
        end
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH byte %0d %s: got 0x%0h, expected 0x%0h at %0t",
                 bytes_checked, what, got, want, $realtime);
        error_count++;
    endtask

    // monitor, predictor feed and watchdog
    always @(posedge i_clk) begin
        t_utf8_byte want;
        logic       moved;
        moved = 1'b0;
        unit_taken <= push && !full;
        if (push && !full) begin
            encode_unit(i_code_unit);
            units_accepted++;
            moved = 1'b1;
        end
        if (pop && !empty) begin
            moved = 1'b1;
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected transaction", o_out_byte, 0);
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.value)
                    report_mismatch("out_byte", o_out_byte, want.value);
                if (o_run_last !== want.run_last)
                    report_mismatch("run_last", o_run_last, want.run_last);
                if (o_string_end !== want.string_end)
                    report_mismatch("string_end", o_string_end, want.string_end);
            end
            bytes_checked++;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d bytes still expected",
                     IDLE_LIMIT, expected_bytes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // driver: bursty push side and patterned pop side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (unit_taken) begin
                void'(pending_units.pop_front());
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                push        <= 1'b0;
                i_code_unit <= UNIT_W'($urandom);
            end else if (pending_units.size() > 0) begin
                push        <= 1'b1;
                i_code_unit <= pending_units[0];
            end else begin
                push        <= 1'b0;
                i_code_unit <= UNIT_W'($urandom);
            end
            pop <= pop_pattern[pop_phase % 16];
            pop_phase++;
            if (pop_phase % 64 == 0)
                pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
    end

    initial begin
        int          kind;
        logic [UNIT_W-1:0] u;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        i_code_unit    = '0;
        unit_taken     = 1'b0;
        held_valid     = 1'b0;
        held_bits      = '0;
        units_accepted = 0;
        bytes_checked  = 0;
        strings_ended  = 0;
        pairs_sent     = 0;
        error_count    = 0;
        idle_cycles    = 0;
        burst_left     = $urandom_range(1, 12);
        gap_left       = 0;
        pop_pattern    = 16'hFFFF;
        pop_phase      = 0;

        foreach (directed_units[i])
            pending_units.push_back(directed_units[i]);
        while (pending_units.size() < $size(directed_units) + N_RANDOM) begin
            kind = $urandom_range(0, 11);
            case (kind)
                0, 1: begin
                    pending_units.push_back(UNIT_W'($urandom_range(1, 16'h007F)));
                end
                2: begin
                    pending_units.push_back(UNIT_W'($urandom_range(16'h0080, 16'h07FF)));
                end
                3, 4: begin
                    u = UNIT_W'($urandom_range(16'h0800, 16'hFFFF));
                    if (u >= SUR_LO && u <= SUR_HI)
                        u = u ^ 16'h2000;
                    pending_units.push_back(u);
                end
                5, 6, 7: begin
                    pending_units.push_back(UNIT_W'($urandom_range(16'hD800, 16'hDBFF)));
                    pending_units.push_back(UNIT_W'($urandom_range(16'hDC00, 16'hDFFF)));
                end
                8: begin
                    pending_units.push_back('0);
                end
                9, 10: begin
                    pending_units.push_back(UNIT_W'($urandom));
                end
                default: begin
                    pending_units.push_back(UNIT_W'($urandom_range(16'hD800, 16'hDFFF)));
                    pending_units.push_back(($urandom_range(0, 3) == 0) ? '0 : UNIT_W'($urandom));
                end
            endcase
        end
        pending_units.push_back('0);
        total_units = pending_units.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (units_accepted < total_units || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d code units, %0d utf-8 bytes checked", units_accepted,
                 bytes_checked);
        $display("%0d surrogate pairs combined, %0d strings terminated", pairs_sent,
                 strings_ended);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
